@@ rtl/plls_pkg.sv @@
// shared types and constants of the piecewise-linear lookup table sampler
package plls_pkg;

    localparam int MAX_POINTS  = 16;
    localparam int PNT_W       = $clog2(MAX_POINTS);
    localparam int CNT_W       = 5;
    localparam int VAL_W       = 16;
    localparam int NUM_COMP    = 3;
    localparam int IDX_W       = 8;
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int DIV_W       = 32;
    localparam int DCNT_W      = $clog2(DIV_W);
    localparam int CFG_W       = 32;
    localparam int ADDR_W      = 3;

    // divide by 255 through a reciprocal and one correction step
    localparam int RECIP_MUL   = 32896;
    localparam int RECIP_SHIFT = 23;
    localparam int TABLE_LAST  = 255;

    localparam logic [1:0] REQ_COLOR   = 2'd0;
    localparam logic [1:0] REQ_OPACITY = 2'd1;
    localparam logic [1:0] REQ_SAMPLE  = 2'd2;

    localparam logic REG_COLOR_COUNT   = 1'b0;
    localparam logic REG_OPACITY_COUNT = 1'b1;

    typedef enum logic [1:0] {
        K_COLOR,
        K_OPACITY,
        K_SAMPLE
    } t_kind;

    typedef struct packed {
        t_kind                                kind;
        logic [PNT_W-1:0]                     slot;
        logic [VAL_W-1:0]                     pos;
        logic [NUM_COMP-1:0][VAL_W-1:0]       val;
        logic [IDX_W-1:0]                     idx;
    } t_item;

    typedef struct packed {
        logic [VAL_W-1:0]                     pos;
        logic [NUM_COMP-1:0][VAL_W-1:0]       val;
    } t_point;

    typedef struct packed {
        logic                                 wr;
        logic                                 start;
        logic [PNT_W-1:0]                     slot;
        t_point                               point;
        logic [IDX_W-1:0]                     idx;
        logic [CNT_W-1:0]                     count;
    } t_lane_cmd;

    typedef struct packed {
        logic                                 busy;
        logic [NUM_COMP-1:0][VAL_W-1:0]       val;
    } t_lane_res;

endpackage

@@ rtl/plls_front.sv @@
// front end: request intake, classification and the queue to the back end
module plls_front import plls_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    output logic              o_full,
    input  logic [1:0]        i_req_type,
    input  logic [PNT_W-1:0]  i_point_slot,
    input  logic [VAL_W-1:0]  i_point_pos,
    input  logic [VAL_W-1:0]  i_value_red,
    input  logic [VAL_W-1:0]  i_value_green,
    input  logic [VAL_W-1:0]  i_value_blue,
    input  logic [VAL_W-1:0]  i_value_alpha,
    input  logic [IDX_W-1:0]  i_sample_index,
    output logic              o_valid,
    input  logic              i_pop,
    output t_item             o_item
);

    t_item              r_slots [QUEUE_DEPTH];
    logic [QPTR_W-1:0]  r_wr_ptr;
    logic [QPTR_W-1:0]  r_rd_ptr;
    logic [QPTR_W:0]    r_fill;
    t_item              n_item;
    logic               keep;
    logic               take;

    assign o_full  = (r_fill == (QPTR_W+1)'(QUEUE_DEPTH));
    assign o_valid = (r_fill != '0);
    assign o_item  = r_slots[r_rd_ptr];
    assign take    = i_pop && o_valid;
    assign keep    = i_push && !o_full &&
                     (i_req_type == REQ_COLOR || i_req_type == REQ_OPACITY ||
                      i_req_type == REQ_SAMPLE);

    always_comb begin
        n_item      = '0;
        n_item.slot = i_point_slot;
        n_item.pos  = i_point_pos;
        n_item.idx  = i_sample_index;
        case (i_req_type)
            REQ_COLOR: begin
                n_item.kind   = K_COLOR;
                n_item.val[0] = i_value_red;
                n_item.val[1] = i_value_green;
                n_item.val[2] = i_value_blue;
            end
            REQ_OPACITY: begin
                n_item.kind   = K_OPACITY;
                n_item.val[0] = i_value_alpha;
            end
            default: begin
                n_item.kind = K_SAMPLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (keep) begin
            r_slots[r_wr_ptr] <= n_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_fill   <= '0;
        end else begin
            if (keep) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (take) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            case ({keep, take})
                2'b10:   r_fill <= r_fill + 1'b1;
                2'b01:   r_fill <= r_fill - 1'b1;
                default: r_fill <= r_fill;
            endcase
        end
    end

endmodule

@@ rtl/plls_div.sv @@
// bit-serial restoring divider, one quotient bit per cycle
module plls_div import plls_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [DIV_W-1:0]  i_dividend,
    input  logic [VAL_W-1:0]  i_divisor,
    output logic              o_busy,
    output logic [DIV_W-1:0]  o_quotient
);

    logic                r_busy;
    logic [DCNT_W-1:0]   r_cnt;
    logic [VAL_W-1:0]    r_dvs;
    logic [VAL_W-1:0]    r_rem;
    logic [DIV_W-1:0]    r_quo;
    logic [VAL_W:0]      rem_sh;
    logic                fits;

    assign rem_sh     = {r_rem, r_quo[DIV_W-1]};
    assign fits       = (rem_sh >= {1'b0, r_dvs});
    assign o_busy     = r_busy;
    assign o_quotient = r_quo;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= DCNT_W'(DIV_W - 1);
        end else if (r_busy) begin
            r_cnt <= r_cnt - 1'b1;
            if (r_cnt == '0) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_dvs <= i_divisor;
            r_rem <= '0;
            r_quo <= i_dividend;
        end else if (r_busy) begin
            r_rem <= fits ? VAL_W'(rem_sh - {1'b0, r_dvs}) : rem_sh[VAL_W-1:0];
            r_quo <= {r_quo[DIV_W-2:0], fits};
        end
    end

endmodule

@@ rtl/plls_lane.sv @@
// one control-point table with its resampling sequencer
module plls_lane import plls_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_lane_cmd  i_cmd,
    output t_lane_res  o_res
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_FIRST,
        S_LAST,
        S_MUL,
        S_RECIP,
        S_FIX,
        S_WALK,
        S_LEFT,
        S_PREP,
        S_DIV,
        S_FIN
    } t_state;

    t_point                          r_mem [MAX_POINTS];
    t_point                          r_rd;
    t_state                          r_state;
    logic [IDX_W-1:0]                r_idx;
    logic [VAL_W-1:0]                r_first;
    logic [VAL_W-1:0]                r_last;
    logic                            r_neg;
    logic [VAL_W-1:0]                r_mag;
    logic [IDX_W+VAL_W-1:0]          r_prod;
    logic [VAL_W-1:0]                r_q;
    logic [VAL_W-1:0]                r_x;
    logic [PNT_W-1:0]                r_k;
    t_point                          r_p0;
    t_point                          r_p1;
    logic                            r_zero;
    logic [NUM_COMP-1:0]             r_sgn;
    logic [NUM_COMP-1:0][VAL_W-1:0]  r_out;

    logic [CNT_W-1:0]                n_pts;
    logic [CNT_W-1:0]                nm1;
    logic [PNT_W-1:0]                raddr;
    logic                            walk_more;
    logic [IDX_W+2*VAL_W-1:0]        est_full;
    logic [IDX_W+VAL_W-1:0]          est255;
    logic [IDX_W+VAL_W-1:0]          rem;
    logic [VAL_W-1:0]                qc;
    logic signed [VAL_W:0]           dx;
    logic signed [VAL_W:0]           w;
    logic [VAL_W-1:0]                w_mag;
    logic signed [VAL_W:0]           dv   [NUM_COMP];
    logic signed [2*VAL_W+1:0]       prod [NUM_COMP];
    logic [NUM_COMP-1:0][DIV_W-1:0]  prod_mag;
    logic [NUM_COMP-1:0]             prod_sgn;
    logic [NUM_COMP-1:0][DIV_W-1:0]  quo;
    logic [NUM_COMP-1:0]             div_busy;
    logic signed [DIV_W+1:0]         sum  [NUM_COMP];
    logic [NUM_COMP-1:0][VAL_W-1:0]  fin;
    logic                            div_start;

    always_comb begin
        if (i_cmd.count < CNT_W'(2)) begin
            n_pts = CNT_W'(2);
        end else if (i_cmd.count > CNT_W'(MAX_POINTS)) begin
            n_pts = CNT_W'(MAX_POINTS);
        end else begin
            n_pts = i_cmd.count;
        end
    end

    assign nm1       = n_pts - 1'b1;
    assign walk_more = ({1'b0, r_k} < nm1) && (r_rd.pos < r_x);
    assign div_start = (r_state == S_PREP);

    always_comb begin
        case (r_state)
            S_FIRST: raddr = nm1[PNT_W-1:0];
            S_FIX:   raddr = PNT_W'(1);
            S_WALK:  raddr = walk_more ? r_k + 1'b1 : r_k - 1'b1;
            default: raddr = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.wr) begin
            r_mem[i_cmd.slot] <= i_cmd.point;
        end
        r_rd <= r_mem[raddr];
    end

    // divide by 255: reciprocal estimate, then at most one step up
    assign est_full = (IDX_W+2*VAL_W)'(r_prod) * (IDX_W+2*VAL_W)'(RECIP_MUL);
    assign est255   = ((IDX_W+VAL_W)'(r_q) << IDX_W) - (IDX_W+VAL_W)'(r_q);
    assign rem      = r_prod - est255;
    assign qc       = (rem >= (IDX_W+VAL_W)'(TABLE_LAST)) ? r_q + 1'b1 : r_q;

    assign dx    = $signed({1'b0, r_x}) - $signed({1'b0, r_p0.pos});
    assign w     = $signed({1'b0, r_p1.pos}) - $signed({1'b0, r_p0.pos});
    assign w_mag = w[VAL_W] ? VAL_W'(-w) : w[VAL_W-1:0];

    for (genvar c = 0; c < NUM_COMP; c++) begin : g_comp
        assign dv[c]       = $signed({1'b0, r_p1.val[c]}) - $signed({1'b0, r_p0.val[c]});
        assign prod[c]     = dx * dv[c];
        assign prod_sgn[c] = prod[c][2*VAL_W+1];
        assign prod_mag[c] = prod_sgn[c] ? DIV_W'(-prod[c]) : prod[c][DIV_W-1:0];

        plls_div u_div (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_start    (div_start),
            .i_dividend (prod_mag[c]),
            .i_divisor  (w_mag),
            .o_busy     (div_busy[c]),
            .o_quotient (quo[c])
        );

        always_comb begin
            if (r_sgn[c]) begin
                sum[c] = $signed({(DIV_W+2-VAL_W)'(0), r_p0.val[c]})
                       - $signed({2'b0, quo[c]});
            end else begin
                sum[c] = $signed({(DIV_W+2-VAL_W)'(0), r_p0.val[c]})
                       + $signed({2'b0, quo[c]});
            end
            if (r_zero) begin
                fin[c] = r_p0.val[c];
            end else if (sum[c] < 0) begin
                fin[c] = '0;
            end else if (sum[c] > $signed((DIV_W+2)'({VAL_W{1'b1}}))) begin
                fin[c] = '1;
            end else begin
                fin[c] = sum[c][VAL_W-1:0];
            end
        end
    end

    assign o_res.busy = (r_state != S_IDLE);
    assign o_res.val  = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (i_cmd.start) begin
                        r_idx   <= i_cmd.idx;
                        r_state <= S_FIRST;
                    end
                end
                S_FIRST: begin
                    r_first <= r_rd.pos;
                    r_state <= S_LAST;
                end
                S_LAST: begin
                    r_last  <= r_rd.pos;
                    r_neg   <= (r_rd.pos < r_first);
                    r_mag   <= (r_rd.pos < r_first) ? r_first - r_rd.pos
                                                    : r_rd.pos - r_first;
                    r_state <= S_MUL;
                end
                S_MUL: begin
                    r_prod  <= (IDX_W+VAL_W)'(r_idx) * (IDX_W+VAL_W)'(r_mag);
                    r_state <= S_RECIP;
                end
                S_RECIP: begin
                    r_q     <= est_full[RECIP_SHIFT +: VAL_W];
                    r_state <= S_FIX;
                end
                S_FIX: begin
                    // a falling range always takes the last point's position
                    r_x     <= r_neg ? r_last : r_first + qc;
                    r_k     <= PNT_W'(1);
                    r_state <= S_WALK;
                end
                S_WALK: begin
                    if (walk_more) begin
                        r_k <= r_k + 1'b1;
                    end else begin
                        r_p1    <= r_rd;
                        r_state <= S_LEFT;
                    end
                end
                S_LEFT: begin
                    r_p0    <= r_rd;
                    r_state <= S_PREP;
                end
                S_PREP: begin
                    r_zero  <= (w == '0);
                    r_sgn   <= prod_sgn ^ {NUM_COMP{w[VAL_W]}};
                    r_state <= S_DIV;
                end
                S_DIV: begin
                    if (!div_busy[0]) begin
                        r_state <= S_FIN;
                    end
                end
                S_FIN: begin
                    r_out   <= fin;
                    r_state <= S_IDLE;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

@@ rtl/piecewise_linear_lut_sampler.sv @@
// Piecewise-linear lookup table sampler. Point writes are stored by the
// back end. For a sample request leaving the request queue, each table is
// walked one control point per cycle through its point memory (one read
// port), and each interpolated component then goes through a 32-step
// bit-serial divider before the result is ready. Both tables are worked on
// side by side. A two-entry request queue lets new requests in while a
// sample runs, and a result register holds the finished result.
module piecewise_linear_lut_sampler import plls_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [ADDR_W-1:0]  paddr,
    input  logic [CFG_W-1:0]   pwdata,
    output logic [CFG_W-1:0]   prdata,
    output logic               pready,
    input  logic               push,
    output logic               full,
    input  logic [1:0]         i_req_type,
    input  logic [PNT_W-1:0]   i_point_slot,
    input  logic [VAL_W-1:0]   i_point_pos,
    input  logic [VAL_W-1:0]   i_value_red,
    input  logic [VAL_W-1:0]   i_value_green,
    input  logic [VAL_W-1:0]   i_value_blue,
    input  logic [VAL_W-1:0]   i_value_alpha,
    input  logic [IDX_W-1:0]   i_sample_index,
    output logic               empty,
    input  logic               pop,
    output logic [VAL_W-1:0]   o_out_red,
    output logic [VAL_W-1:0]   o_out_green,
    output logic [VAL_W-1:0]   o_out_blue,
    output logic [VAL_W-1:0]   o_out_alpha
);

    typedef enum logic {
        B_IDLE,
        B_RUN
    } t_bstate;

    logic [CNT_W-1:0]  r_color_count;
    logic [CNT_W-1:0]  r_opacity_count;
    t_bstate           r_bstate;
    logic              r_out_valid;
    logic [VAL_W-1:0]  r_red;
    logic [VAL_W-1:0]  r_green;
    logic [VAL_W-1:0]  r_blue;
    logic [VAL_W-1:0]  r_alpha;

    logic              q_valid;
    logic              q_pop;
    t_item             q_item;
    t_lane_cmd         col_cmd;
    t_lane_cmd         op_cmd;
    t_lane_res         col_res;
    t_lane_res         op_res;
    logic              cfg_wr;
    logic              issue;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;
    assign prdata = (paddr[2] == REG_OPACITY_COUNT) ? CFG_W'(r_opacity_count)
                                                    : CFG_W'(r_color_count);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_color_count   <= CNT_W'(2);
            r_opacity_count <= CNT_W'(2);
        end else if (cfg_wr) begin
            if (paddr[2] == REG_OPACITY_COUNT) begin
                r_opacity_count <= pwdata[CNT_W-1:0];
            end else begin
                r_color_count <= pwdata[CNT_W-1:0];
            end
        end
    end

    plls_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_push         (push),
        .o_full         (full),
        .i_req_type     (i_req_type),
        .i_point_slot   (i_point_slot),
        .i_point_pos    (i_point_pos),
        .i_value_red    (i_value_red),
        .i_value_green  (i_value_green),
        .i_value_blue   (i_value_blue),
        .i_value_alpha  (i_value_alpha),
        .i_sample_index (i_sample_index),
        .o_valid        (q_valid),
        .i_pop          (q_pop),
        .o_item         (q_item)
    );

    assign issue = (r_bstate == B_IDLE) && q_valid;
    assign q_pop = issue;

    always_comb begin
        col_cmd             = '0;
        col_cmd.slot        = q_item.slot;
        col_cmd.point.pos   = q_item.pos;
        col_cmd.point.val   = q_item.val;
        col_cmd.idx         = q_item.idx;
        col_cmd.count       = r_color_count;
        op_cmd              = col_cmd;
        op_cmd.count        = r_opacity_count;
        col_cmd.wr          = issue && (q_item.kind == K_COLOR);
        op_cmd.wr           = issue && (q_item.kind == K_OPACITY);
        col_cmd.start       = issue && (q_item.kind == K_SAMPLE);
        op_cmd.start        = col_cmd.start;
    end

    plls_lane u_color (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (col_cmd),
        .o_res   (col_res)
    );

    plls_lane u_opacity (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (op_cmd),
        .o_res   (op_res)
    );

    assign empty       = !r_out_valid;
    assign o_out_red   = r_red;
    assign o_out_green = r_green;
    assign o_out_blue  = r_blue;
    assign o_out_alpha = r_alpha;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bstate    <= B_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            if (pop && r_out_valid) begin
                r_out_valid <= 1'b0;
            end
            case (r_bstate)
                B_IDLE: begin
                    if (issue && q_item.kind == K_SAMPLE) begin
                        r_bstate <= B_RUN;
                    end
                end
                B_RUN: begin
                    if (!col_res.busy && !op_res.busy && !r_out_valid) begin
                        r_red       <= col_res.val[0];
                        r_green     <= col_res.val[1];
                        r_blue      <= col_res.val[2];
                        r_alpha     <= op_res.val[0];
                        r_out_valid <= 1'b1;
                        r_bstate    <= B_IDLE;
                    end
                end
                default: begin
                    r_bstate <= B_IDLE;
                end
            endcase
        end
    end

endmodule
